@@ rtl/core/utf8_stream_decoder_macros.svh @@
// Assertion macros for the UTF-8 stream decoder.
// Expects signals clk and arst_n in the scope of use; no other dependencies.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UTF8D_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/utf8d_pkg.sv @@
// Shared widths, constants, result type and extender lookup for the UTF-8 decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned LEN_W  = 3;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [CP_W-1:0] ZWJ_CP         = 21'h00200D;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] seq_length;
		logic             error;
		logic             is_extender;
		logic             last;
	} utf8d_result_t;

	// Combining marks, variation selectors and zero width joiner.
	function automatic logic is_extender_cp(input logic [CP_W-1:0] cp);
		logic hit;
		hit = (cp >= 21'h00FE00 && cp <= 21'h00FE0F) ||
		      (cp >= 21'h0E0100 && cp <= 21'h0E01EF) ||
		      (cp == ZWJ_CP) ||
		      (cp >= 21'h000300 && cp <= 21'h00036F) ||
		      (cp >= 21'h001AB0 && cp <= 21'h001AFF) ||
		      (cp >= 21'h001DC0 && cp <= 21'h001DFF) ||
		      (cp >= 21'h0020D0 && cp <= 21'h0020FF) ||
		      (cp >= 21'h00FE20 && cp <= 21'h00FE2F);
		return hit;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/utf8d_in_if.sv @@
// Byte channel of the UTF-8 decoder: valid/ready plus one stream byte and an end-of-stream flag.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface utf8d_in_if import utf8d_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_in;
	logic              end_of_stream;

	modport source (output valid, output byte_in, output end_of_stream, input ready);
	modport sink   (input valid, input byte_in, input end_of_stream, output ready);
endinterface

`default_nettype wire

@@ rtl/core/utf8d_out_if.sv @@
// Result channel of the UTF-8 decoder: valid/ready plus one decoded code point with its length and flags.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface utf8d_out_if import utf8d_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CP_W-1:0]  code_point;
	logic [LEN_W-1:0] seq_length;
	logic             error;
	logic             is_extender;
	logic             last;

	modport source (output valid, output code_point, output seq_length, output error,
		output is_extender, output last, input ready);
	modport sink   (input valid, input code_point, input seq_length, input error,
		input is_extender, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/utf8_stream_decoder.sv @@
// UTF-8 stream decoder, top level.
// Depends on utf8d_pkg, utf8d_in_if, utf8d_out_if and utf8_stream_decoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte beat per cycle on rx and gives one result beat on tx for
// each completed UTF-8 sequence (1 to 4 bytes), for each invalid lead byte
// (U+FFFD, error set) and for a sequence cut short by end_of_stream (bits
// gathered so far, error set). A continuation byte without the 10 prefix is
// still consumed and flags the sequence's result as an error. No overlong,
// surrogate or range checks are made. Each byte is decoded in the cycle it
// is accepted, against the sequence state, and the result lands in a single
// output register on the accepting edge. rx.ready is high whenever that register is
// empty or is being drained in the same cycle, so the sustained rate is one
// byte per cycle; rx stalls only while a result sits unread on tx. After a
// beat with end_of_stream the sequence state is back at reset.

`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder import utf8d_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	utf8d_in_if.sink    rx,
	utf8d_out_if.source tx
);

	// Sequence state.
	logic [CP_W-1:0]  acc_q;
	logic [1:0]       rem_q;     // continuation bytes still expected
	logic [LEN_W-1:0] len_q;     // length given by the lead byte
	logic             serr_q;    // bad continuation seen

	logic [CP_W-1:0]  acc_d;
	logic [1:0]       rem_d;
	logic [LEN_W-1:0] len_d;
	logic             serr_d;

	// Result register.
	logic          out_valid_q;
	utf8d_result_t res_q;
	utf8d_result_t res_d;
	logic          emit;

	logic rx_take;

	// Accept while the result register is empty or drains this cycle.
	assign rx.ready = !out_valid_q || tx.ready;
	assign rx_take  = rx.valid && rx.ready;

	// Continuation path intermediates.
	logic [CP_W-1:0] acc_cont;
	logic            serr_cont;
	logic [1:0]      rem_cont;

	assign acc_cont  = {acc_q[CP_W-7:0], rx.byte_in[5:0]};
	assign serr_cont = serr_q || (rx.byte_in[7:6] != 2'b10);
	assign rem_cont  = rem_q - 2'd1;

	always_comb begin
		acc_d  = acc_q;
		rem_d  = rem_q;
		len_d  = len_q;
		serr_d = serr_q;
		emit   = 1'b0;
		res_d  = '0;

		if (rem_q == 2'd0) begin
			// Lead byte.
			case (rx.byte_in) inside
				8'b0???????: begin
					emit  = 1'b1;
					res_d = '{code_point: {13'd0, rx.byte_in}, seq_length: 3'd1,
						error: 1'b0, is_extender: is_extender_cp({13'd0, rx.byte_in}),
						last: rx.end_of_stream};
				end
				8'b110?????: begin
					acc_d = {16'd0, rx.byte_in[4:0]};
					rem_d = 2'd1;
					len_d = 3'd2;
				end
				8'b1110????: begin
					acc_d = {17'd0, rx.byte_in[3:0]};
					rem_d = 2'd2;
					len_d = 3'd3;
				end
				8'b11110???: begin
					acc_d = {18'd0, rx.byte_in[2:0]};
					rem_d = 2'd3;
					len_d = 3'd4;
				end
				default: begin
					// Stray continuation or 0xF8..0xFF.
					emit  = 1'b1;
					res_d = '{code_point: REPLACEMENT_CP, seq_length: 3'd1, error: 1'b1,
						is_extender: 1'b0, last: rx.end_of_stream};
				end
			endcase
			serr_d = 1'b0;
			// Lead byte that closes the stream: truncated, one byte long.
			if (!emit && rx.end_of_stream) begin
				emit  = 1'b1;
				res_d = '{code_point: acc_d, seq_length: 3'd1, error: 1'b1,
					is_extender: 1'b0, last: 1'b1};
			end
		end else begin
			acc_d  = acc_cont;
			serr_d = serr_cont;
			rem_d  = rem_cont;
			if (rem_cont == 2'd0) begin
				emit  = 1'b1;
				res_d = '{code_point: acc_cont, seq_length: len_q, error: serr_cont,
					is_extender: is_extender_cp(acc_cont), last: rx.end_of_stream};
			end else if (rx.end_of_stream) begin
				emit  = 1'b1;
				res_d = '{code_point: acc_cont, seq_length: len_q - {1'b0, rem_cont},
					error: 1'b1, is_extender: 1'b0, last: 1'b1};
			end
		end

		// Any result closes the sequence.
		if (emit) begin
			acc_d  = '0;
			rem_d  = 2'd0;
			len_d  = '0;
			serr_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			rem_q  <= 2'd0;
			len_q  <= '0;
			serr_q <= 1'b0;
		end else if (rx_take) begin
			acc_q  <= acc_d;
			rem_q  <= rem_d;
			len_q  <= len_d;
			serr_q <= serr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rx_take) begin
			out_valid_q <= emit;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take && emit) begin
			res_q <= res_d;
		end
	end

	assign tx.valid       = out_valid_q;
	assign tx.code_point  = res_q.code_point;
	assign tx.seq_length  = res_q.seq_length;
	assign tx.error       = res_q.error;
	assign tx.is_extender = res_q.is_extender;
	assign tx.last        = res_q.last;

	// Checks on decoder state and results.
	`UTF8D_ASSERT_SAME(a_len_covers_rem, rem_q != 2'd0, len_q > {1'b0, rem_q}, "length below remaining count")
	`UTF8D_ASSERT_SAME(a_ascii_range, tx.valid && !tx.error && tx.seq_length == 3'd1, tx.code_point[CP_W-1:7] == '0, "clean one-byte result above 0x7F")
	`UTF8D_ASSERT_NEXT(a_eos_clears, rx_take && rx.end_of_stream, rem_q == 2'd0 && out_valid_q, "end of stream left sequence open")
	`UTF8D_ASSERT_SAME(a_ready_when_empty, !out_valid_q, rx.ready, "stalled with empty result register")

endmodule

`default_nettype wire
